FILE: design/oaids_pkg.sv
// Shared constants for the ordered array insert/delete/search core.
// Holds field widths, request codes and status codes; no dependencies.
package oaids_pkg;

  // Default number of entries held by the array
  localparam int DEF_CAPACITY = 64;

  // Payload field widths
  localparam int REQ_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 6;

  // Request codes carried on the input tuser
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd5;

  // Status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

FILE: design/ordered_array_insert_delete_search_core.sv
// Ordered array of signed 32-bit entries with clear, append, insert, delete,
// search and dump requests. Depends on oaids_pkg.
//
// Usage:
//   Requests enter on the slave stream: tuser carries the request code,
//   tdata carries position and value. Results leave on the master stream:
//   tuser carries the status, tdata the index and value, tlast marks the
//   final result of a request. Every request gives one result, except a
//   dump of a non-empty array, which gives one result per stored entry.
//   The entries live in a single-port-read, single-port-write memory; one
//   sequencer walks it with at most one read and one write per step.
//   Clear, append and a request refused for a bad position, a full array or
//   an unknown code need no walk of the memory. Insert shifts the entries
//   up one place from the top down to the position, then writes the value.
//   Delete shifts the entries above the position down one place. Search
//   scans from index zero to the first match or the end of the entries, and
//   dump reads one entry per step, waiting while the output register is full.
//   Each shift or scan step is one registered memory read, then
//   the write or compare. The input is ready only while no request is active.
//   A result waits in the output register while the receiver stalls; the
//   core takes the next request meanwhile and holds its own result until
//   the register is free. Reset empties the array (count to zero) and drops
//   any pending result; memory contents are not cleared.
module ordered_array_insert_delete_search_core
  import oaids_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [6:0] position, [38:7] item_value, [39] zero
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] req_type
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [5:0] found_index, [37:6] entry_value, [39:38] zero
  output logic [2:0]  m_axis_tuser_o,  // [2:0] status
  output logic        m_axis_tlast_o   // last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_DEL_RD  = 4'd3;
  localparam logic [3:0] S_DEL_WR  = 4'd4;
  localparam logic [3:0] S_SRC_RD  = 4'd5;
  localparam logic [3:0] S_SRC_CMP = 4'd6;
  localparam logic [3:0] S_DMP_RD  = 4'd7;
  localparam logic [3:0] S_DMP_OUT = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [CW-1:0]       res_idx_q, res_idx_d;

  // Output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [VAL_W-1:0]    out_val_q, out_val_d;
  logic                out_last_q, out_last_d;
  logic                out_load, out_free;

  // Memory ports
  logic [VAL_W-1:0]    mem [CAPACITY];
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [VAL_W-1:0]    wr_data, rd_data_q;

  logic                s_accept;
  logic [POS_W-1:0]    pos_in, cnt_ext, idx_ext;
  logic [CW-1:0]       idx_inc;
  logic                full;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pos_in   = s_axis_tdata_i[POS_W-1:0];
  assign cnt_ext  = POS_W'(cnt_q);
  assign idx_ext  = POS_W'(idx_q);
  assign idx_inc  = idx_q + CW'(1);
  assign full     = (cnt_q == CW'(CAPACITY));

  // Sequence one request through the shared memory port
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[AW-1:0];
    wr_data      = rd_data_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q[AW-1:0];
    out_load     = 1'b0;
    out_status_d = res_status_q;
    out_idx_d    = IDX_W'(res_idx_q);
    out_val_d    = '0;
    out_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          pos_d        = pos_in;
          val_d        = s_axis_tdata_i[POS_W +: VAL_W];
          res_status_d = ST_OK;
          res_idx_d    = '0;
          state_d      = S_RESP;
          case (s_axis_tuser_i)
            REQ_CLEAR: begin
              cnt_d = '0;
            end
            REQ_APPEND: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_q[AW-1:0];
                wr_data = s_axis_tdata_i[POS_W +: VAL_W];
                cnt_d   = cnt_q + CW'(1);
              end
            end
            REQ_INSERT: begin
              if (pos_in > cnt_ext) begin
                res_status_d = ST_INVALID;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            REQ_DELETE: begin
              if (pos_in >= cnt_ext) begin
                res_status_d = ST_INVALID;
              end else begin
                idx_d   = CW'(pos_in);
                state_d = S_DEL_RD;
              end
            end
            REQ_SEARCH: begin
              idx_d   = '0;
              state_d = S_SRC_RD;
            end
            REQ_DUMP: begin
              if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_DMP_RD;
              end
            end
            default: begin
              res_status_d = ST_INVALID;
            end
          endcase
        end
      end
      // Shift entries up one place, from the top down to the position
      S_INS_RD: begin
        if (idx_ext > pos_q) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_q - CW'(1));
          state_d = S_INS_WR;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_q[AW-1:0];
          wr_data = val_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_RESP;
        end
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_q - CW'(1);
        state_d = S_INS_RD;
      end
      // Shift entries down one place, from the position up to the top
      S_DEL_RD: begin
        if (idx_inc < cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
          state_d = S_DEL_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end
      end
      S_DEL_WR: begin
        wr_en   = 1'b1;
        idx_d   = idx_inc;
        state_d = S_DEL_RD;
      end
      // Scan from index zero for the first match
      S_SRC_RD: begin
        if (idx_q < cnt_q) begin
          rd_en   = 1'b1;
          state_d = S_SRC_CMP;
        end else begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end
      end
      S_SRC_CMP: begin
        if (rd_data_q == val_q) begin
          res_idx_d = idx_q;
          state_d   = S_RESP;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SRC_RD;
        end
      end
      // Stream entries out, one result per entry
      S_DMP_RD: begin
        rd_en   = 1'b1;
        state_d = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_idx_d    = IDX_W'(idx_q);
          out_val_d    = rd_data_q;
          out_last_d   = (idx_inc == cnt_q);
          idx_d        = idx_inc;
          state_d      = (idx_inc == cnt_q) ? S_IDLE : S_DMP_RD;
        end
      end
      // Hold the single result until the output register is free
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold request and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_val_q    <= out_val_d;
      out_last_q   <= out_last_d;
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_val_q, out_idx_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: design/oaids_checker.sv
// Port-level checks for the ordered array core, bound to its top level.
// Depends on oaids_pkg.
module oaids_checker
  import oaids_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= ST_EMPTY)
    else $error("undefined status code");

  // Any failure status is a lone, zeroed, final result
  a_fail_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |->
      m_axis_tlast_o && m_axis_tdata_o == 40'd0)
    else $error("failure result not final or not zero");

  // One request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while busy");

endmodule

bind ordered_array_insert_delete_search_core oaids_checker u_oaids_checker (.*);
